// ----- src/ntcat_pkg.sv -----
// Shared constants and lookup tables for the NTC thermistor converter.
// Used by the front, back and top-level modules; depends on nothing else.
package ntcat_pkg;

    localparam int NTC_POINTS = 34;
    localparam int OHM_W      = 19;
    localparam int SEG_W      = 6;
    localparam int TEMP_W     = 15;
    localparam int PULLUP_W   = 17;
    localparam int FRAC_W     = 9;
    localparam logic [PULLUP_W-1:0] PULLUP_RESET = PULLUP_W'(10000);

    // Table resistance in ohms, coldest point first, 5.0 C apart.
    localparam logic [OHM_W-1:0] NTC_OHM [NTC_POINTS] = '{
        19'd335500, 19'd247690, 19'd184110, 19'd138480, 19'd104650, 19'd79180,
        19'd60210, 19'd46050, 19'd35360, 19'd26960, 19'd20760, 19'd16130,
        19'd12650, 19'd10000, 19'd7970, 19'd6410, 19'd5180, 19'd4221,
        19'd3460, 19'd2845, 19'd2351, 19'd1953, 19'd1629, 19'd1365,
        19'd1148, 19'd970, 19'd825, 19'd705, 19'd604, 19'd520,
        19'd449, 19'd388, 19'd337, 19'd294};

    // Table temperature in hundredths of a degree C.
    localparam logic signed [TEMP_W-1:0] NTC_CENTI [NTC_POINTS] = '{
        -15'sd4000, -15'sd3500, -15'sd3000, -15'sd2500, -15'sd2000, -15'sd1500,
        -15'sd1000, -15'sd500, 15'sd0, 15'sd500, 15'sd1000, 15'sd1500,
        15'sd2000, 15'sd2500, 15'sd3000, 15'sd3500, 15'sd4000, 15'sd4500,
        15'sd5000, 15'sd5500, 15'sd6000, 15'sd6500, 15'sd7000, 15'sd7500,
        15'sd8000, 15'sd8500, 15'sd9000, 15'sd9500, 15'sd10000, 15'sd10500,
        15'sd11000, 15'sd11500, 15'sd12000, 15'sd12500};

endpackage

// ----- src/ntcat_front.sv -----
// Front pipeline: resistance cross-products, range check and segment search.
// Depends on ntcat_pkg.
module ntcat_front
    import ntcat_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [ADC_BITS-1:0]       raw,
    input  logic [PULLUP_W-1:0]       pullup_ohm,
    output logic                      out_valid,
    output logic                      out_ok,
    output logic [SEG_W-1:0]          out_seg,
    output logic [PULLUP_W+ADC_BITS-1:0] out_pr,
    output logic [ADC_BITS-1:0]       out_d
);

    localparam int PW   = PULLUP_W + ADC_BITS;
    localparam int PRDW = OHM_W + ADC_BITS;
    localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

    logic                v1_reg, v2_reg, v3_reg;
    logic                rail1_reg, rail2_reg;
    logic [PW-1:0]       pr1_reg, pr2_reg, pr3_reg;
    logic [ADC_BITS-1:0] d1_reg, d2_reg, d3_reg;
    logic [PRDW-1:0]     p_reg [NTC_POINTS];
    logic [PRDW-1:0]     p_next [NTC_POINTS];
    logic                ok3_reg, ok3_next;
    logic [SEG_W-1:0]    seg3_reg, seg3_next;
    logic [NTC_POINTS-1:0] ge;

    always_comb
    begin
        for (int k = 0; k < NTC_POINTS; k++)
        begin
            p_next[k] = PRDW'(NTC_OHM[k]) * PRDW'(d1_reg);
        end
    end

    // ge is monotonic along the table, so the first segment is found from
    // the coldest point at which the resistance reaches the lower bound.
    always_comb
    begin
        for (int k = 0; k < NTC_POINTS; k++)
        begin
            ge[k] = PRDW'(pr2_reg) >= p_reg[k];
        end
        seg3_next = '0;
        for (int k = NTC_POINTS - 1; k >= 1; k--)
        begin
            if (ge[k])
            begin
                seg3_next = SEG_W'(k - 1);
            end
        end
        ok3_next = !rail2_reg && (PRDW'(pr2_reg) <= p_reg[0]) && ge[NTC_POINTS-1];
        if (!ok3_next)
        begin
            seg3_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr1_reg   <= PW'(pullup_ohm) * PW'(raw);
            d1_reg    <= FULL - raw;
            rail1_reg <= (raw == '0) || (raw == FULL);
            for (int k = 0; k < NTC_POINTS; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            pr2_reg   <= pr1_reg;
            d2_reg    <= d1_reg;
            rail2_reg <= rail1_reg;
            pr3_reg   <= pr2_reg;
            d3_reg    <= d2_reg;
            ok3_reg   <= ok3_next;
            seg3_reg  <= seg3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_ok    = ok3_reg;
    assign out_seg   = seg3_reg;
    assign out_pr    = pr3_reg;
    assign out_d     = d3_reg;

endmodule

// ----- src/ntcat_fifo.sv -----
// Small register queue that decouples the front and back pipelines.
// Depends on nothing.
module ntcat_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= din;
        end
    end

    assign dout  = mem[rd_reg];
    assign full  = cnt_reg == (AW+1)'(DEPTH);
    assign empty = cnt_reg == '0;

endmodule

// ----- src/ntcat_back.sv -----
// Back pipeline: segment interpolation and a bit-per-stage rounding divider.
// Depends on ntcat_pkg.
module ntcat_back
    import ntcat_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         in_ok,
    input  logic [SEG_W-1:0]             in_seg,
    input  logic [PULLUP_W+ADC_BITS-1:0] in_pr,
    input  logic [ADC_BITS-1:0]          in_d,
    output logic                         out_valid,
    output logic                         out_ok,
    output logic signed [TEMP_W-1:0]     out_temp
);

    localparam int PW   = PULLUP_W + ADC_BITS;
    localparam int PRDW = OHM_W + ADC_BITS;
    localparam int DENW = 17 + ADC_BITS;
    localparam int NW   = DENW + 10;
    localparam int DW   = DENW + 1;

    logic             v1_reg;
    logic             ok1_reg;
    logic [SEG_W-1:0] seg1_reg;
    logic [PRDW-1:0]  hi1_reg;
    logic [DENW-1:0]  den1_reg;
    logic [PW-1:0]    pr1_reg;
    logic [SEG_W-1:0] seg_lo;
    logic [PRDW-1:0]  x2;

    // Divider stages; index 0 is the dividend set up for the first bit.
    logic             dv_reg  [FRAC_W+1];
    logic             dok_reg [FRAC_W+1];
    logic [SEG_W-1:0] dseg_reg [FRAC_W+1];
    logic [NW-1:0]    rem_reg [FRAC_W+1];
    logic [DW-1:0]    dd_reg  [FRAC_W+1];
    logic [FRAC_W-1:0] q_reg  [FRAC_W+1];
    logic [NW-1:0]    rem_next [FRAC_W];
    logic [FRAC_W-1:0] q_next [FRAC_W];
    logic [NW-1:0]    dsh;

    assign seg_lo = in_seg + SEG_W'(1);
    assign x2     = hi1_reg - PRDW'(pr1_reg);

    always_comb
    begin
        for (int j = 0; j < FRAC_W; j++)
        begin
            dsh         = NW'(dd_reg[j]) << (FRAC_W - 1 - j);
            rem_next[j] = rem_reg[j];
            q_next[j]   = q_reg[j];
            if (rem_reg[j] >= dsh)
            begin
                rem_next[j] = rem_reg[j] - dsh;
                q_next[j][FRAC_W-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int j = 0; j <= FRAC_W; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            dv_reg[0] <= v1_reg;
            for (int j = 0; j < FRAC_W; j++)
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi1_reg  <= PRDW'(NTC_OHM[in_seg]) * PRDW'(in_d);
            den1_reg <= DENW'(NTC_OHM[in_seg] - NTC_OHM[seg_lo]) * DENW'(in_d);
            pr1_reg  <= in_pr;
            ok1_reg  <= in_ok;
            seg1_reg <= in_seg;
            // Rounding half up: floor((1000*x + den) / (2*den)).
            rem_reg[0]  <= NW'(x2) * NW'(1000) + NW'(den1_reg);
            dd_reg[0]   <= {den1_reg, 1'b0};
            q_reg[0]    <= '0;
            dok_reg[0]  <= ok1_reg;
            dseg_reg[0] <= seg1_reg;
            for (int j = 0; j < FRAC_W; j++)
            begin
                rem_reg[j+1]  <= rem_next[j];
                q_reg[j+1]    <= q_next[j];
                dd_reg[j+1]   <= dd_reg[j];
                dok_reg[j+1]  <= dok_reg[j];
                dseg_reg[j+1] <= dseg_reg[j];
            end
        end
    end

    assign out_valid = dv_reg[FRAC_W];
    assign out_ok    = dok_reg[FRAC_W];
    assign out_temp  = dok_reg[FRAC_W]
                     ? NTC_CENTI[dseg_reg[FRAC_W]] + $signed({6'b0, q_reg[FRAC_W]})
                     : '0;

endmodule

// ----- src/ntc_adc_to_temperature.sv -----
// Top level of the NTC thermistor ADC-to-temperature converter.
// Depends on ntcat_pkg, ntcat_front, ntcat_fifo and ntcat_back.

// Takes one ADC code per clock unless stalled and returns one result per code: a valid flag
// and the temperature in signed hundredths of a degree C, interpolated in a
// 34-point table from -40 C to +125 C (0 when the code is a rail code or the
// resistance lies outside the table). Throughput is one item per cycle when
// neither side stalls; the path runs through the three-stage front (multiply,
// table products, segment search), the queue register, two set-up stages and
// nine divider stages that produce one quotient bit each, and the output
// register. Either side may stall on its own through a four-item queue.
module ntc_adc_to_temperature
    import ntcat_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0] s_tdata,  // [ADC_BITS-1:0] raw_code
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,  // [0] temp_valid, [15:1] temperature_centi_c
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [PULLUP_W-1:0]           cfg_data
);

    localparam int PW = PULLUP_W + ADC_BITS;
    localparam int QW = 1 + SEG_W + PW + ADC_BITS;

    logic [PULLUP_W-1:0]      pullup_reg;
    logic                     en_f, en_b;
    logic                     f_valid, f_ok;
    logic [SEG_W-1:0]         f_seg, q_seg;
    logic [PW-1:0]            f_pr, q_pr;
    logic [ADC_BITS-1:0]      f_d, q_d;
    logic                     q_ok, q_full, q_empty, q_push, q_pop;
    logic [QW-1:0]            q_dout;
    logic                     b_valid, b_ok;
    logic signed [TEMP_W-1:0] b_temp;
    logic                     m_tvalid_reg;
    logic                     ok_reg;
    logic [TEMP_W-1:0]        temp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pullup_reg <= PULLUP_RESET;
        end
        else if (cfg_valid)
        begin
            pullup_reg <= cfg_data;
        end
    end

    assign en_f     = !f_valid || !q_full;
    assign s_tready = en_f;
    assign q_push   = f_valid && !q_full;

    ntcat_front #(.ADC_BITS(ADC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en_f),
        .in_valid   (s_tvalid),
        .raw        (s_tdata[ADC_BITS-1:0]),
        .pullup_ohm (pullup_reg),
        .out_valid  (f_valid),
        .out_ok     (f_ok),
        .out_seg    (f_seg),
        .out_pr     (f_pr),
        .out_d      (f_d)
    );

    ntcat_fifo #(.W(QW), .DEPTH(4)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_ok, f_seg, f_pr, f_d}),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {q_ok, q_seg, q_pr, q_d} = q_dout;

    assign en_b  = !m_tvalid_reg || m_tready;
    assign q_pop = en_b && !q_empty;

    ntcat_back #(.ADC_BITS(ADC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_b),
        .in_valid  (q_pop),
        .in_ok     (q_ok),
        .in_seg    (q_seg),
        .in_pr     (q_pr),
        .in_d      (q_d),
        .out_valid (b_valid),
        .out_ok    (b_ok),
        .out_temp  (b_temp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            m_tvalid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            ok_reg   <= b_ok;
            temp_reg <= b_temp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {temp_reg, ok_reg};

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[15:1] == '0))
        else $error("invalid result carries a non-zero temperature");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |->
            ($signed(m_tdata[15:1]) >= -15'sd4000 && $signed(m_tdata[15:1]) <= 15'sd12500))
        else $error("temperature outside the table range");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && f_valid) |-> !s_tready)
        else $error("front advanced into a full queue");

endmodule
